### rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Field widths, channel lane indexes and hue sector codes for the HSV to
// packed RGB pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int unsigned HUE_W  = 16;
	localparam int unsigned SAT_W  = 9;
	localparam int unsigned BRI_W  = 9;
	localparam int unsigned BYTE_W = 8;

	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CH_R   = 0;
	localparam int unsigned CH_G   = 1;
	localparam int unsigned CH_B   = 2;

	typedef logic [BYTE_W-1:0] byte_t;

	// one code per sixth of a turn, named by the channel that ramps in it
	typedef enum logic [2:0] {
		SEC_G_FALL = 3'd0,
		SEC_B_RISE = 3'd1,
		SEC_R_FALL = 3'd2,
		SEC_G_RISE = 3'd3,
		SEC_B_FALL = 3'd4,
		SEC_R_RISE = 3'd5
	} sector_t;

endpackage

### rtl/hsv_to_packed_rgb_core.sv
// ----------------------------------------------------------------------------
// hsv_to_packed_rgb_core
// Six-stage pipeline that turns a hue, saturation and brightness word into
// three LED channel bytes (red, blue, green order).
//
//   port        dir  width  role
//   start       in   1      input word present
//   busy        out  1      never set, a word enters every cycle
//   hue         in   16     fraction of a turn
//   saturation  in   9      1.8 fixed point
//   brightness  in   9      1.8 fixed point
//   done        out  1      result word present for this one cycle
//   byte_low    out  8      red byte
//   byte_mid    out  8      blue byte
//   byte_high   out  8      green byte
//
// Each word passes the registers of stages one to six, and done is the stage
// six valid bit; throughput is one word per cycle, set by the stage depth (one
// multiply or one wide add per stage). Reset clears the valid bits only. The
// receiver takes every result, so nothing stalls and busy stays low.
// ----------------------------------------------------------------------------
module hsv_to_packed_rgb_core #(
	parameter int unsigned HUE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [hsvrgb_pkg::HUE_W-1:0]      hue,
	input  logic [hsvrgb_pkg::SAT_W-1:0]      saturation,
	input  logic [hsvrgb_pkg::BRI_W-1:0]      brightness,
	output logic                              done,
	output hsvrgb_pkg::byte_t                 byte_low,
	output hsvrgb_pkg::byte_t                 byte_mid,
	output hsvrgb_pkg::byte_t                 byte_high
);

	localparam int unsigned HB   = HUE_BITS;
	localparam int unsigned NCH  = hsvrgb_pkg::NUM_CH;
	localparam int unsigned H6W  = HB + 3;
	localparam int unsigned LVW  = HB + 1;
	localparam int unsigned SCW  = HB + 10;
	localparam int unsigned SUMW = HB + 12;
	localparam int unsigned KCW  = 10;
	localparam int unsigned PCW  = HB + 19;
	localparam int unsigned PSW  = HB + 23;
	localparam int unsigned BW   = HB + 24;
	localparam int unsigned MW   = BW + 8;
	localparam logic [H6W-1:0] ONE_H6 = H6W'(1) << HB;
	localparam logic [H6W-1:0] SIX_H6 = H6W'(6) << HB;
	localparam logic [LVW-1:0] ONE_LV = LVW'(1) << HB;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1: sector and fraction
	logic [HB+15:0] hue_ext;
	logic [H6W-1:0] h6_raw, h6_wrap;
	logic [2:0]     sector_s1;
	logic [HB-1:0]  frac_s1;
	logic [hsvrgb_pkg::SAT_W-1:0] sat_s1, sat_s2, sat_s3;
	logic [hsvrgb_pkg::BRI_W-1:0] bri_s1;

	// stage 2: levels scaled by brightness
	logic [LVW-1:0] lvl [NCH];
	logic [SCW-1:0] scaled_s2 [NCH];
	logic [SCW-1:0] scaled_s3 [NCH];

	// stage 3: sum and complement factor
	logic [SUMW-1:0]       sum_s3;
	logic signed [KCW-1:0] kc_s3;

	// stage 4: products
	logic [PCW-1:0]        prod_ch_s4 [NCH];
	logic signed [PSW-1:0] prod_sum_s4;

	// stage 5: blends
	logic signed [BW-1:0]  blend_s5 [NCH];

	// stage 6: bytes
	logic [MW-1:0]             mag255 [NCH];
	logic [MW-1:0]             trunc  [NCH];
	hsvrgb_pkg::byte_t         byte_nx [NCH];
	hsvrgb_pkg::byte_t         byte_s6 [NCH];

	assign busy = 1'b0;

	assign hue_ext = (HB + 16)'(hue);
	assign h6_raw  = (H6W'(hue_ext[HB-1:0]) << 2) + (H6W'(hue_ext[HB-1:0]) << 1) + ONE_H6;
	assign h6_wrap = (h6_raw >= SIX_H6) ? (h6_raw - SIX_H6) : h6_raw;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			lvl[c] = '0;
		end
		case (hsvrgb_pkg::sector_t'(sector_s1))
			hsvrgb_pkg::SEC_G_FALL: begin
				lvl[hsvrgb_pkg::CH_R] = ONE_LV;
				lvl[hsvrgb_pkg::CH_G] = ONE_LV - LVW'(frac_s1);
			end
			hsvrgb_pkg::SEC_B_RISE: begin
				lvl[hsvrgb_pkg::CH_R] = ONE_LV;
				lvl[hsvrgb_pkg::CH_B] = LVW'(frac_s1);
			end
			hsvrgb_pkg::SEC_R_FALL: begin
				lvl[hsvrgb_pkg::CH_R] = ONE_LV - LVW'(frac_s1);
				lvl[hsvrgb_pkg::CH_B] = ONE_LV;
			end
			hsvrgb_pkg::SEC_G_RISE: begin
				lvl[hsvrgb_pkg::CH_B] = ONE_LV;
				lvl[hsvrgb_pkg::CH_G] = LVW'(frac_s1);
			end
			hsvrgb_pkg::SEC_B_FALL: begin
				lvl[hsvrgb_pkg::CH_B] = ONE_LV - LVW'(frac_s1);
				lvl[hsvrgb_pkg::CH_G] = ONE_LV;
			end
			default: begin
				lvl[hsvrgb_pkg::CH_G] = ONE_LV;
				lvl[hsvrgb_pkg::CH_R] = LVW'(frac_s1);
			end
		endcase
	end

	// clamp negative blends to zero, scale by 255, drop fraction, saturate
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			if (!blend_s5[c][BW-1] && (blend_s5[c] != '0)) begin
				mag255[c] = (MW'(blend_s5[c]) << 8) - MW'(blend_s5[c]);
			end else begin
				mag255[c] = '0;
			end
			trunc[c] = mag255[c] >> (HB + 16);
			if (trunc[c] > MW'(255)) begin
				byte_nx[c] = 8'hFF;
			end else begin
				byte_nx[c] = trunc[c][hsvrgb_pkg::BYTE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= h6_wrap[H6W-1:HB];
		frac_s1   <= h6_wrap[HB-1:0];
		sat_s1    <= saturation;
		bri_s1    <= brightness;

		sat_s2 <= sat_s1;
		for (int c = 0; c < NCH; c++) begin
			scaled_s2[c] <= SCW'(lvl[c]) * SCW'(bri_s1);
		end

		sat_s3 <= sat_s2;
		for (int c = 0; c < NCH; c++) begin
			scaled_s3[c] <= scaled_s2[c];
		end
		sum_s3 <= SUMW'(scaled_s2[hsvrgb_pkg::CH_R]) + SUMW'(scaled_s2[hsvrgb_pkg::CH_G])
			+ SUMW'(scaled_s2[hsvrgb_pkg::CH_B]);
		kc_s3  <= KCW'(signed'(11'sd256 - signed'({2'b00, sat_s2})));

		for (int c = 0; c < NCH; c++) begin
			prod_ch_s4[c] <= PCW'(scaled_s3[c]) * PCW'(sat_s3);
		end
		prod_sum_s4 <= PSW'(signed'({1'b0, sum_s3})) * PSW'(kc_s3);

		for (int c = 0; c < NCH; c++) begin
			blend_s5[c] <= BW'(signed'({1'b0, prod_ch_s4[c]})) + BW'(prod_sum_s4);
		end

		for (int c = 0; c < NCH; c++) begin
			byte_s6[c] <= byte_nx[c];
		end
	end

	assign done      = v_s6;
	assign byte_low  = byte_s6[hsvrgb_pkg::CH_R];
	assign byte_mid  = byte_s6[hsvrgb_pkg::CH_B];
	assign byte_high = byte_s6[hsvrgb_pkg::CH_G];

endmodule
